/* hdl/bds_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bds_pkg: shared types and constants of the 2x2 box downsampler
// Holds the dimension limits, field widths, register indexes and the
// descriptor that travels from the control stage to the averaging stage.
// ----------------------------------------------------------------------------
package bds_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 16384;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;

  localparam int SAMPLE_W = 16;
  localparam int PAIR_W   = SAMPLE_W + 1;
  localparam int SUM_W    = SAMPLE_W + 2;
  localparam int WIDTH_W  = 13;
  localparam int HEIGHT_W = 15;
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int ADDR_W   = $clog2(LINE_DEPTH);
  localparam int OW_W     = $clog2(MAX_WIDTH / 2) + 1;
  localparam int OH_W     = $clog2(MAX_HEIGHT / 2) + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = HEIGHT_W;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 13'd4096;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 15'd4096;
  localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_WIDTH);
  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX   = HEIGHT_W'(MAX_HEIGHT);

  typedef struct packed {
    logic              emit;
    logic              use_line;
    logic [1:0]        shift;
    logic [PAIR_W-1:0] pair;
    logic              row_end;
    logic              frame_end;
  } bds_item_t;

endpackage
`default_nettype wire

/* hdl/bds_line_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bds_line_ram: pair sum line store
// Simple dual-port synchronous RAM, one write and one read port, with the
// read data registered and held while the read enable is low.
// ----------------------------------------------------------------------------
module bds_line_ram (
  input  wire                         clk,
  input  wire                         wr_en,
  input  wire  [bds_pkg::ADDR_W-1:0]  wr_addr,
  input  wire  [bds_pkg::PAIR_W-1:0]  wr_data,
  input  wire                         rd_en,
  input  wire  [bds_pkg::ADDR_W-1:0]  rd_addr,
  output logic [bds_pkg::PAIR_W-1:0]  rd_data_r
);
  import bds_pkg::*;

  logic [PAIR_W-1:0] mem [LINE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* hdl/bds_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bds_ctrl: configuration, position counters and line store commands
// Holds the clamped image size, tracks the raster position, forms the
// horizontal pair sums and decides per sample whether it is stored,
// combined with the line store or dropped.
// ----------------------------------------------------------------------------
module bds_ctrl (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             cfg_valid,
  input  wire  [bds_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [bds_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire                             accept,
  input  wire  [bds_pkg::SAMPLE_W-1:0]    sample,
  output bds_pkg::bds_item_t              item,
  output logic                            wr_en,
  output logic                            rd_en,
  output logic [bds_pkg::ADDR_W-1:0]      line_addr
);
  import bds_pkg::*;

  logic [WIDTH_W-1:0]  w_r,  w_nxt;
  logic [HEIGHT_W-1:0] h_r,  h_nxt;
  logic [OW_W-1:0]     ow_r, ow_nxt;
  logic [OH_W-1:0]     oh_r, oh_nxt;
  logic                w_one_r, w_one_nxt;
  logic                h_one_r, h_one_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [SAMPLE_W-1:0] pending_r, pending_nxt;

  logic                cfg_hit;
  logic [WIDTH_W-1:0]  w_raw;
  logic [HEIGHT_W-1:0] h_raw;
  logic                col_last, row_last, have_pair, out_row_last, out_frame_last;
  logic [PAIR_W-1:0]   pair;

  assign w_raw   = cfg_wdata[WIDTH_W-1:0];
  assign h_raw   = cfg_wdata[HEIGHT_W-1:0];
  assign cfg_hit = cfg_valid &&
                   (cfg_index == REG_SOURCE_WIDTH || cfg_index == REG_SOURCE_HEIGHT);

  always_comb begin
    w_nxt  = w_r;
    h_nxt  = h_r;
    if (cfg_valid && cfg_index == REG_SOURCE_WIDTH) begin
      priority if (w_raw == '0)        w_nxt = WIDTH_W'(1);
      else if (w_raw > WIDTH_MAX)      w_nxt = WIDTH_MAX;
      else                             w_nxt = w_raw;
    end
    if (cfg_valid && cfg_index == REG_SOURCE_HEIGHT) begin
      priority if (h_raw == '0)        h_nxt = HEIGHT_W'(1);
      else if (h_raw > HEIGHT_MAX)     h_nxt = HEIGHT_MAX;
      else                             h_nxt = h_raw;
    end
    w_one_nxt = (w_nxt == WIDTH_W'(1));
    h_one_nxt = (h_nxt == HEIGHT_W'(1));
    ow_nxt    = w_one_nxt ? OW_W'(1) : OW_W'(w_nxt >> 1);
    oh_nxt    = h_one_nxt ? OH_W'(1) : OH_W'(h_nxt >> 1);
  end

  assign col_last  = (({1'b0, col_r} + WIDTH_W'(1)) == w_r);
  assign row_last  = (({1'b0, row_r} + HEIGHT_W'(1)) == h_r);
  assign have_pair = w_one_r || col_r[0];
  assign pair      = w_one_r ? {1'b0, sample}
                             : ({1'b0, pending_r} + {1'b0, sample});
  assign line_addr = col_r[COL_W-1:1];

  assign out_row_last   = (({1'b0, line_addr} + OW_W'(1)) == ow_r);
  assign out_frame_last = out_row_last &&
                          (h_one_r || (({1'b0, row_r[ROW_W-1:1]} + OH_W'(1)) == oh_r));

  always_comb begin
    item.emit      = have_pair && (h_one_r || row_r[0]);
    item.use_line  = !h_one_r;
    item.shift     = 2'(!w_one_r) + 2'(!h_one_r);
    item.pair      = pair;
    item.row_end   = out_row_last;
    item.frame_end = out_frame_last;
  end

  assign wr_en = accept && have_pair && !h_one_r && !row_r[0] && !row_last;
  assign rd_en = accept && have_pair && !h_one_r && row_r[0];

  always_comb begin
    col_nxt     = col_r;
    row_nxt     = row_r;
    pending_nxt = pending_r;
    if (cfg_hit) begin
      col_nxt     = '0;
      row_nxt     = '0;
      pending_nxt = '0;
    end else if (accept) begin
      if (!w_one_r && !col_r[0] && !col_last) begin
        pending_nxt = sample;
      end
      if (col_last) begin
        col_nxt = '0;
        row_nxt = row_last ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r       <= WIDTH_RESET;
      h_r       <= HEIGHT_RESET;
      ow_r      <= OW_W'(WIDTH_RESET >> 1);
      oh_r      <= OH_W'(HEIGHT_RESET >> 1);
      w_one_r   <= 1'b0;
      h_one_r   <= 1'b0;
      col_r     <= '0;
      row_r     <= '0;
      pending_r <= '0;
    end else begin
      w_r       <= w_nxt;
      h_r       <= h_nxt;
      ow_r      <= ow_nxt;
      oh_r      <= oh_nxt;
      w_one_r   <= w_one_nxt;
      h_one_r   <= h_one_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      pending_r <= pending_nxt;
    end
  end

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, col_r} < w_r) && ({1'b0, row_r} < h_r))
    else $error("position counter outside the configured image");

  a_store_or_combine: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && rd_en))
    else $error("line store written and read for the same sample");

  a_single_column_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !cfg_hit && w_one_r |=> col_r == '0)
    else $error("column counter moved in a one-column image");

endmodule
`default_nettype wire

/* hdl/bds_out.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bds_out: averaging stage and output register
// Adds the stored upper pair sum to the lower one as the line store data
// arrives, scales by the sample count and holds the result for transfer.
// ----------------------------------------------------------------------------
module bds_out (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           accept,
  input  bds_pkg::bds_item_t            item,
  input  wire  [bds_pkg::PAIR_W-1:0]    line_data,
  output logic                          hold,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic [bds_pkg::SAMPLE_W-1:0]  out_averaged_sample,
  output logic                          out_row_end,
  output logic                          out_frame_end
);
  import bds_pkg::*;

  logic              s1_valid_r, s1_valid_nxt;
  bds_item_t         s1_r;
  logic              out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] avg_r;
  logic              row_end_r, frame_end_r;
  logic              advance;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  scaled;

  assign advance = !out_valid_r || !out_stall;
  assign hold    = s1_valid_r && !advance;

  assign sum = {1'b0, s1_r.pair} + (s1_r.use_line ? {1'b0, line_data} : SUM_W'(0));

  always_comb begin
    unique case (s1_r.shift)
      2'd0:    scaled = sum;
      2'd1:    scaled = sum >> 1;
      default: scaled = sum >> 2;
    endcase
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = item.emit;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = advance ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= item;
    end
    if (advance && s1_valid_r) begin
      avg_r       <= scaled[SAMPLE_W-1:0];
      row_end_r   <= s1_r.row_end;
      frame_end_r <= s1_r.frame_end;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_averaged_sample = avg_r;
  assign out_row_end         = row_end_r;
  assign out_frame_end       = frame_end_r;

  a_frame_end_closes_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!frame_end_r || row_end_r))
    else $error("frame end without row end");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    hold |-> !accept)
    else $error("new sample taken while the averaging stage is blocked");

  a_held_stage_kept: assert property (@(posedge clk) disable iff (!rst_n)
    hold |=> s1_valid_r && $stable(s1_r))
    else $error("blocked averaging stage lost its contents");

  a_line_scaled: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_r.use_line |-> s1_r.shift != 2'd0)
    else $error("vertical average without scaling");

endmodule
`default_nettype wire

/* hdl/box_downsample_2x2.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// box_downsample_2x2: 2x2 box filter downsampler for 16-bit height images
// Samples enter in raster order on the in_ channel, one transfer per clock
// when in_stall is low. Each output sample on the out_ channel is the
// truncated average of a 2x2 source block; an odd last column or row is
// dropped, and a dimension of 1 gives one output column or row averaged over
// the samples that exist. out_row_end and out_frame_end mark the last sample
// of an output row and of the image.
// The cfg_ channel writes the source width (index 0) and height (index 1);
// cfg_ready is always high and a write to index 0 or 1 restarts the frame.
// Write only while no result is outstanding.
// The completing sample's result is registered in the averaging stage and
// then in the output register. The block takes one sample per cycle while
// in_stall is low. When out_stall holds a result, one more result waits in
// the averaging stage and in_stall rises only then.
// Reset sets both dimensions to 4096 and starts a new frame; the line store
// is not cleared because every frame writes a row before reading it.
// ----------------------------------------------------------------------------
module box_downsample_2x2 (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire  [bds_pkg::SAMPLE_W-1:0]    in_height_sample,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic [bds_pkg::SAMPLE_W-1:0]    out_averaged_sample,
  output logic                            out_row_end,
  output logic                            out_frame_end,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [bds_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [bds_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import bds_pkg::*;

  logic              accept;
  logic              hold;
  bds_item_t         item;
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] line_addr;
  logic [PAIR_W-1:0] line_data;

  assign cfg_ready = 1'b1;
  assign in_stall  = hold;
  assign accept    = in_valid && !hold;

  bds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .sample    (in_height_sample),
    .item      (item),
    .wr_en     (wr_en),
    .rd_en     (rd_en),
    .line_addr (line_addr)
  );

  bds_line_ram u_line (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (line_addr),
    .wr_data   (item.pair),
    .rd_en     (rd_en),
    .rd_addr   (line_addr),
    .rd_data_r (line_data)
  );

  bds_out u_out (
    .clk                 (clk),
    .rst_n               (rst_n),
    .accept              (accept),
    .item                (item),
    .line_data           (line_data),
    .hold                (hold),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_averaged_sample (out_averaged_sample),
    .out_row_end         (out_row_end),
    .out_frame_end       (out_frame_end)
  );

endmodule
`default_nettype wire

/* tb/sv/tb_box_downsample_2x2.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_box_downsample_2x2: self-checking bench for the 2x2 box downsampler
// Streams height samples through the block under random valid and stall
// gaps, predicts every averaged output sample with its row and frame end
// flags from a behavioral copy of the line store and counters, and compares
// each output transfer with the oldest prediction. Covers the reset
// dimensions, clamped zero and oversize dimensions, dropped odd edges, frame
// wrap, restart on register writes and many small random frames.
// ----------------------------------------------------------------------------
module tb_box_downsample_2x2;
  import bds_pkg::*;

  typedef struct packed {
    logic [SAMPLE_W-1:0] averaged_sample;
    logic                row_end;
    logic                frame_end;
  } downsample_result_t;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RANDOM_ITEMS_PER_SEGMENT = 250;
  localparam int unsigned EDGE_SAMPLES = 64;
  localparam int unsigned MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [SAMPLE_W-1:0] in_height_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [SAMPLE_W-1:0] out_averaged_sample;
  logic out_row_end;
  logic out_frame_end;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic in_taken = 1'b0;
  logic cfg_taken = 1'b0;
  int unsigned send_idle_pct = 35;
  int unsigned recv_idle_pct = 52;
  int unsigned samples_queued = 0;
  int unsigned samples_taken = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  logic [SAMPLE_W-1:0] sample_queue[$];
  downsample_result_t expected_averages[$];

  logic [WIDTH_W-1:0]  src_width = WIDTH_RESET;
  logic [HEIGHT_W-1:0] src_height = HEIGHT_RESET;
  logic [COL_W-1:0]    column_pos = '0;
  logic [ROW_W-1:0]    row_pos = '0;
  logic [PAIR_W-1:0]   pending_pair = '0;
  logic [PAIR_W-1:0]   line_sums[LINE_DEPTH];

  box_downsample_2x2 DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_height_sample    (in_height_sample),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_averaged_sample (out_averaged_sample),
    .out_row_end         (out_row_end),
    .out_frame_end       (out_frame_end),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int unsigned effective_dim(input int unsigned value,
                                                input int unsigned limit);
    if (value == 0) return 1;
    if (value > limit) return limit;
    return value;
  endfunction

  function automatic void write_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_SOURCE_WIDTH: begin
        src_width = data[WIDTH_W-1:0];
        column_pos = '0;
        row_pos = '0;
        pending_pair = '0;
      end
      REG_SOURCE_HEIGHT: begin
        src_height = data[HEIGHT_W-1:0];
        column_pos = '0;
        row_pos = '0;
        pending_pair = '0;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void predict_downsample(input logic [SAMPLE_W-1:0] sample);
    int unsigned w, h, c, r, ow, oh, ox, shift, pair, avg;
    logic have_pair, emit, row_last;
    downsample_result_t res;
    w = effective_dim(src_width, MAX_WIDTH);
    h = effective_dim(src_height, MAX_HEIGHT);
    c = column_pos;
    r = row_pos;
    ow = (w == 1) ? 1 : (w >> 1);
    oh = (h == 1) ? 1 : (h >> 1);
    shift = (w == 1) ? 0 : 1;
    pair = 0;
    avg = 0;
    have_pair = 1'b0;
    emit = 1'b0;
    if (w == 1) begin
      pair = sample;
      have_pair = 1'b1;
    end else if ((c % 2) != 0) begin
      pair = pending_pair + sample;
      have_pair = 1'b1;
    end else if (c + 1 < w) begin
      pending_pair = PAIR_W'(sample);
    end
    if (have_pair) begin
      ox = c >> 1;
      if (h == 1) begin
        avg = pair >> shift;
        emit = 1'b1;
      end else if ((r % 2) != 0) begin
        avg = (line_sums[ox] + pair) >> (shift + 1);
        emit = 1'b1;
      end else if (r + 1 < h) begin
        line_sums[ox] = PAIR_W'(pair);
      end
      if (emit) begin
        row_last = (ox + 1 == ow);
        res.averaged_sample = SAMPLE_W'(avg);
        res.row_end = row_last;
        res.frame_end = row_last && (((r >> 1) + 1 == oh) || (h == 1));
        expected_averages.push_back(res);
      end
    end
    if (c + 1 >= w) begin
      column_pos = '0;
      row_pos = (r + 1 >= h) ? '0 : ROW_W'(r + 1);
    end else begin
      column_pos = COL_W'(c + 1);
    end
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic queue_sample(input logic [SAMPLE_W-1:0] sample);
    sample_queue.push_back(sample);
    samples_queued++;
  endtask

  task automatic wait_for_drain();
    while (samples_taken != samples_queued || expected_averages.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg_port(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_dimensions(input logic [CFG_DATA_W-1:0] width_data,
                                input logic [CFG_DATA_W-1:0] height_data);
    wait_for_drain();
    write_cfg_port(REG_SOURCE_WIDTH, width_data);
    write_cfg_port(REG_SOURCE_HEIGHT, height_data);
  endtask

  task automatic run_random_frames(input int unsigned item_target);
    int unsigned done, w, h, frame_items, n;
    done = 0;
    while (done < item_target) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
      h = $urandom_range(0, 7);
      set_dimensions({2'($urandom), WIDTH_W'(w)}, HEIGHT_W'(h));
      frame_items = effective_dim(w, MAX_WIDTH) * effective_dim(h, MAX_HEIGHT);
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 2 * frame_items);
      end else begin
        n = frame_items * $urandom_range(1, 3);
      end
      repeat (n) queue_sample(random_sample());
      done += n;
    end
  endtask

  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (sample_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_height_sample <= sample_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    downsample_result_t want;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else if (!rst_n) begin
      in_taken <= 1'b0;
      cfg_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      cfg_taken <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) begin
        write_register(cfg_index, cfg_wdata);
      end
      if (in_valid && !in_stall) begin
        samples_taken++;
        predict_downsample(in_height_sample);
      end
      if (out_valid && !out_stall) begin
        if (expected_averages.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("unexpected output transfer: avg=%0d row_end=%0b frame_end=%0b",
                     out_averaged_sample, out_row_end, out_frame_end);
          end
        end else begin
          want = expected_averages.pop_front();
          if (out_averaged_sample !== want.averaged_sample ||
              out_row_end !== want.row_end || out_frame_end !== want.frame_end) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
              $display("mismatch: exp avg=%0d re=%0b fe=%0b, got avg=%0d re=%0b fe=%0b",
                       want.averaged_sample, want.row_end, want.frame_end,
                       out_averaged_sample, out_row_end, out_frame_end);
            end
          end
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset dimensions of 4096 by 4096: part of the first row gives no output.
    repeat (EDGE_SAMPLES) queue_sample(random_sample());

    // Zero dimensions act as one: every sample is its own frame.
    set_dimensions('0, '0);
    queue_sample('1);
    queue_sample('0);
    queue_sample('1);
    queue_sample(16'd1);

    // Odd width and height drop the last column and row; the second frame
    // is cut after its first row.
    set_dimensions(15'd3, 15'd3);
    repeat (9) queue_sample('1);
    queue_sample('0);
    queue_sample(16'd1);
    queue_sample('1);

    // A write to an unused index must not restart the frame.
    wait_for_drain();
    write_cfg_port(REG_UNUSED, '1);
    queue_sample('1);
    queue_sample(16'd2);
    queue_sample('0);

    // A width write in the middle of a frame restarts it.
    wait_for_drain();
    write_cfg_port(REG_SOURCE_WIDTH, 15'd2);
    queue_sample('1);
    queue_sample('1);
    queue_sample(16'd1);
    queue_sample(16'd2);
    queue_sample('1);
    queue_sample('0);

    set_dimensions(15'd2, 15'd1);
    queue_sample('1);
    queue_sample(16'd65534);
    set_dimensions(15'd1, 15'd2);
    queue_sample('1);
    queue_sample(16'd3);

    run_random_frames(RANDOM_ITEMS_PER_SEGMENT);

    wait_for_drain();
    send_idle_pct = 52;
    recv_idle_pct = 35;
    run_random_frames(RANDOM_ITEMS_PER_SEGMENT);

    // Oversize width clamps to the maximum; the start of one long output row.
    set_dimensions(15'h1FFF, 15'd1);
    repeat (EDGE_SAMPLES) queue_sample(random_sample());

    wait_for_drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_frames(RANDOM_ITEMS_PER_SEGMENT);

    // Oversize height clamps to the maximum; the top of one tall column.
    set_dimensions({2'b11, WIDTH_W'(1)}, 15'h7FFF);
    repeat (EDGE_SAMPLES) queue_sample(random_sample());

    wait_for_drain();
    if (error_count == 0 && expected_averages.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
